[sv/assert_macros.svh]
// assertion macros shared by the rtl files of the distortion block
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define ADB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ADB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADB_ASSERT(lbl, prop, msg)
`define ADB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/adb_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the arctan distortion blend block
// no dependencies
package adb_pkg;

  localparam int GAIN_W     = 16;
  localparam int BLEND_W    = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int ANGLE_BITS = 30;
  localparam int ZW         = 32;

  localparam logic [BLEND_W-1:0] BLEND_ONE    = 17'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_UNITY   = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_GAIN  = 8'd0,
    CFG_DRIVE_GAIN  = 8'd1,
    CFG_BLEND       = 8'd2,
    CFG_OUTPUT_GAIN = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  input_gain;
    logic [GAIN_W-1:0]  drive_gain;
    logic [BLEND_W-1:0] blend_amount;
    logic [GAIN_W-1:0]  output_gain;
  } cfg_regs_t;

  // atan(2^-i) in units where 2^30 is a quarter turn
  localparam logic [ZW-1:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

[sv/adb_stream_if.sv]
`timescale 1ns / 1ps
// valid/ready stream interfaces for the sample input and result channels
// no dependencies
interface adb_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface adb_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

[sv/arctan_distortion_blend.sv]
`timescale 1ns / 1ps
// Arctangent soft-clip distortion with dry/wet blend: takes one sample per clock cycle
// while the skid entry is empty. A result leaves after three gain stages, one cordic stage
// per step, five blend and output gain stages and one output register; throughput is one
// sample per cycle while the sink keeps up, set by the fully pipelined datapath.
// When the sink stalls, one result parks in a skid entry and then the whole pipeline holds,
// so nothing is lost or repeated. Configuration writes land directly in the gain and blend
// registers and should happen only while no sample is in flight.
// depends on adb_pkg, adb_stream_if, adb_gain, adb_cordic, adb_mix, adb_skid
module arctan_distortion_blend #(
  parameter int SAMPLE_BITS  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  adb_in_if.sink                            in_ch,
  adb_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [adb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  adb_pkg::cfg_regs_t cfg_r;

  logic                          pipe_en;
  logic                          g_v, g_neg, g_zero;
  logic [SAMPLE_BITS+7:0]        g_mag;
  logic signed [SAMPLE_BITS-1:0] g_x;
  logic                          c_v, c_neg, c_zero;
  logic signed [adb_pkg::ZW-1:0] c_z;
  logic signed [SAMPLE_BITS-1:0] c_x;
  logic                          m_v;
  logic signed [SAMPLE_BITS-1:0] m_sample;
  logic [SAMPLE_BITS-1:0]        s_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_gain   <= adb_pkg::GAIN_UNITY;
      cfg_r.drive_gain   <= adb_pkg::GAIN_UNITY;
      cfg_r.blend_amount <= adb_pkg::BLEND_ONE;
      cfg_r.output_gain  <= adb_pkg::GAIN_UNITY;
    end else if (cfg_we) begin
      case (adb_pkg::cfg_idx_t'(cfg_index))
        adb_pkg::CFG_INPUT_GAIN:  cfg_r.input_gain   <= cfg_data[adb_pkg::GAIN_W-1:0];
        adb_pkg::CFG_DRIVE_GAIN:  cfg_r.drive_gain   <= cfg_data[adb_pkg::GAIN_W-1:0];
        adb_pkg::CFG_BLEND:       cfg_r.blend_amount <= cfg_data[adb_pkg::BLEND_W-1:0];
        adb_pkg::CFG_OUTPUT_GAIN: cfg_r.output_gain  <= cfg_data[adb_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipeline moves as one unless the skid entry is occupied
  assign in_ch.ready = pipe_en;

  adb_gain #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (in_ch.valid),
    .x_in     (in_ch.sample_in),
    .cfg      (cfg_r),
    .out_v    (g_v),
    .mag_out  (g_mag),
    .neg_out  (g_neg),
    .zero_out (g_zero),
    .x_out    (g_x)
  );

  adb_cordic #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_v     (g_v),
    .mag_in   (g_mag),
    .neg_in   (g_neg),
    .zero_in  (g_zero),
    .x_in     (g_x),
    .out_v    (c_v),
    .z_out    (c_z),
    .neg_out  (c_neg),
    .zero_out (c_zero),
    .x_out    (c_x)
  );

  adb_mix #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_v       (c_v),
    .z_in       (c_z),
    .neg_in     (c_neg),
    .zero_in    (c_zero),
    .x_in       (c_x),
    .cfg        (cfg_r),
    .out_v      (m_v),
    .sample_out (m_sample)
  );

  adb_skid #(
    .W(SAMPLE_BITS)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (m_v),
    .in_data   (m_sample),
    .in_ready  (pipe_en),
    .out_v     (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (s_data)
  );

  assign out_ch.sample_out = s_data;

endmodule

[sv/adb_gain.sv]
`timescale 1ns / 1ps
// input and drive gain stages: two multiplies, rounding, clamp to +/-256.0
// depends on adb_pkg and assert_macros.svh
`include "assert_macros.svh"
module adb_gain #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  adb_pkg::cfg_regs_t            cfg,
  output logic                          out_v,
  output logic [SAMPLE_BITS+7:0]        mag_out,
  output logic                          neg_out,
  output logic                          zero_out,
  output logic signed [SAMPLE_BITS-1:0] x_out
);

  localparam int P1_W  = SAMPLE_BITS + 17;
  localparam int G1_W  = SAMPLE_BITS + 5;
  localparam int P2_W  = SAMPLE_BITS + 22;
  localparam int G2_W  = SAMPLE_BITS + 10;
  localparam int MAG_W = SAMPLE_BITS + 8;
  localparam logic [P1_W-1:0] HALF1 = P1_W'(2048);
  localparam logic [P2_W-1:0] HALF2 = P2_W'(2048);
  localparam logic signed [G2_W-1:0] LIM = G2_W'(1) << (SAMPLE_BITS + 7);

  logic v1_r, v2_r, v3_r;
  logic signed [SAMPLE_BITS-1:0] x1_r, x2_r, x3_r;
  logic signed [P1_W-1:0] p1_r, p1_nxt;
  logic signed [P2_W-1:0] p2_r, p2_nxt;
  logic [P1_W-1:0] s1;
  logic [P2_W-1:0] s2;
  logic signed [G1_W-1:0] g1;
  logic signed [G2_W-1:0] g2, g2_abs;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt, zero_r, zero_nxt;

  assign p1_nxt = x_in * $signed({1'b0, cfg.input_gain});

  // round half up, then take the integer part
  assign s1     = p1_r + HALF1;
  assign g1     = $signed(s1[P1_W-1:12]);
  assign p2_nxt = g1 * $signed({1'b0, cfg.drive_gain});

  assign s2       = p2_r + HALF2;
  assign g2       = $signed(s2[P2_W-1:12]);
  assign g2_abs   = g2[G2_W-1] ? -g2 : g2;
  assign neg_nxt  = g2[G2_W-1];
  assign zero_nxt = (g2 == '0);
  assign mag_nxt  = (g2_abs > LIM) ? LIM[MAG_W-1:0] : g2_abs[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p1_nxt;
      x1_r   <= x_in;
      p2_r   <= p2_nxt;
      x2_r   <= x1_r;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      zero_r <= zero_nxt;
      x3_r   <= x2_r;
    end
  end

  assign out_v    = v3_r;
  assign mag_out  = mag_r;
  assign neg_out  = neg_r;
  assign zero_out = zero_r;
  assign x_out    = x3_r;

  `ADB_ASSERT(a_mag_clamped, v3_r |-> (mag_r <= LIM[MAG_W-1:0]), "driven magnitude above limit")
  `ADB_ASSERT(a_zero_mag, (v3_r && zero_r) |-> (mag_r == '0), "zero flag with nonzero magnitude")

endmodule

[sv/adb_cordic.sv]
`timescale 1ns / 1ps
// pipelined vectoring cordic, one rotation per stage, angle in Q.30 quarter turns
// depends on adb_pkg
module adb_cordic #(
  parameter int SAMPLE_BITS  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [SAMPLE_BITS+7:0]        mag_in,
  input  logic                          neg_in,
  input  logic                          zero_in,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic                          out_v,
  output logic signed [adb_pkg::ZW-1:0] z_out,
  output logic                          neg_out,
  output logic                          zero_out,
  output logic signed [SAMPLE_BITS-1:0] x_out
);

  localparam int CW = SAMPLE_BITS + 10;
  localparam int ZW = adb_pkg::ZW;
  localparam logic signed [CW-1:0] ONE = CW'(1) << (SAMPLE_BITS - 1);

  logic                          v_r    [CORDIC_STEPS];
  logic signed [CW-1:0]          cx_r   [CORDIC_STEPS];
  logic signed [CW-1:0]          cy_r   [CORDIC_STEPS];
  logic signed [ZW-1:0]          z_r    [CORDIC_STEPS];
  logic                          neg_r  [CORDIC_STEPS];
  logic                          zero_r [CORDIC_STEPS];
  logic signed [SAMPLE_BITS-1:0] x_r    [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic                          v_i, neg_i, zero_i;
    logic signed [SAMPLE_BITS-1:0] x_i;
    logic signed [CW-1:0]          cx_i, cy_i, dx, dy, cx_nxt, cy_nxt;
    logic signed [ZW-1:0]          z_i, z_nxt, ang;

    if (i == 0) begin : g_first
      // start vector (1.0, |g|)
      assign cx_i   = ONE;
      assign cy_i   = $signed({2'b00, mag_in});
      assign z_i    = '0;
      assign v_i    = in_v;
      assign neg_i  = neg_in;
      assign zero_i = zero_in;
      assign x_i    = x_in;
    end else begin : g_next
      assign cx_i   = cx_r[i-1];
      assign cy_i   = cy_r[i-1];
      assign z_i    = z_r[i-1];
      assign v_i    = v_r[i-1];
      assign neg_i  = neg_r[i-1];
      assign zero_i = zero_r[i-1];
      assign x_i    = x_r[i-1];
    end

    assign dx  = cy_i >>> i;
    assign dy  = cx_i >>> i;
    assign ang = $signed(adb_pkg::ATAN_TAB[i]);

    always_comb begin
      if (!cy_i[CW-1]) begin
        cx_nxt = cx_i + dx;
        cy_nxt = cy_i - dy;
        z_nxt  = z_i + ang;
      end else begin
        cx_nxt = cx_i - dx;
        cy_nxt = cy_i + dy;
        z_nxt  = z_i - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]   <= cx_nxt;
        cy_r[i]   <= cy_nxt;
        z_r[i]    <= z_nxt;
        neg_r[i]  <= neg_i;
        zero_r[i] <= zero_i;
        x_r[i]    <= x_i;
      end
    end
  end

  assign out_v    = v_r[CORDIC_STEPS-1];
  assign z_out    = z_r[CORDIC_STEPS-1];
  assign neg_out  = neg_r[CORDIC_STEPS-1];
  assign zero_out = zero_r[CORDIC_STEPS-1];
  assign x_out    = x_r[CORDIC_STEPS-1];

endmodule

[sv/adb_mix.sv]
`timescale 1ns / 1ps
// angle to sample scaling, dry/wet blend, output gain and final saturation
// depends on adb_pkg and assert_macros.svh
`include "assert_macros.svh"
module adb_mix #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic signed [adb_pkg::ZW-1:0] z_in,
  input  logic                          neg_in,
  input  logic                          zero_in,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  adb_pkg::cfg_regs_t            cfg,
  output logic                          out_v,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int FRAC = SAMPLE_BITS - 1;
  localparam int ZW   = adb_pkg::ZW;
  localparam int DW   = ZW + 2;
  localparam int PW   = SAMPLE_BITS + 18;
  localparam int HW   = PW - 16;
  localparam int PHW  = HW + 17;
  localparam int TW   = SAMPLE_BITS + 35;
  localparam int RW   = TW - 28;
  localparam logic signed [DW-1:0] SMAX_D = (DW'(1) <<< FRAC) - DW'(1);
  localparam logic signed [RW-1:0] SMAX_R = (RW'(1) <<< FRAC) - RW'(1);
  localparam logic signed [RW-1:0] SMIN_R = -(RW'(1) <<< FRAC);
  localparam logic signed [SAMPLE_BITS-1:0] SMIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [TW-1:0] HALF_T = TW'(1) << 27;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [DW-1:0] dz, dc;
  logic signed [SAMPLE_BITS-1:0] d_r, d_nxt, x1_r;
  logic [adb_pkg::BLEND_W-1:0] b, nb;
  logic signed [PW-1:0] pd_r, pd_nxt, px_r, px_nxt, m_r, m_nxt;
  logic signed [HW-1:0] mh;
  logic signed [PHW-1:0] ph_r, ph_nxt;
  logic [31:0] pl_r, pl_nxt;
  logic [TW-1:0] tot;
  logic signed [RW-1:0] r;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;

  // angle in Q.30 quarter turns to the sample's fraction bits
  if (FRAC < adb_pkg::ANGLE_BITS) begin : g_round
    localparam int SH = adb_pkg::ANGLE_BITS - FRAC;
    logic [ZW-1:0] zs;
    assign zs = z_in + (ZW'(1) << (SH - 1));
    assign dz = DW'($signed(zs[ZW-1:SH]));
  end else begin : g_widen
    assign dz = DW'(z_in) <<< (FRAC - adb_pkg::ANGLE_BITS);
  end

  always_comb begin
    if (zero_in || dz[DW-1]) begin
      dc = '0;
    end else if (dz > SMAX_D) begin
      dc = SMAX_D;
    end else begin
      dc = dz;
    end
    d_nxt = neg_in ? -dc[SAMPLE_BITS-1:0] : dc[SAMPLE_BITS-1:0];
  end

  // blend above unity acts as fully distorted
  assign b      = (cfg.blend_amount > adb_pkg::BLEND_ONE) ? adb_pkg::BLEND_ONE
                                                          : cfg.blend_amount;
  assign nb     = adb_pkg::BLEND_ONE - b;
  assign pd_nxt = d_r * $signed({1'b0, b});
  assign px_nxt = x1_r * $signed({1'b0, nb});

  assign m_nxt = pd_r + px_r;

  // split the mix so the output gain multiply stays narrow
  assign mh     = $signed(m_r[PW-1:16]);
  assign ph_nxt = mh * $signed({1'b0, cfg.output_gain});
  assign pl_nxt = m_r[15:0] * cfg.output_gain;

  assign tot = (TW'(ph_r) << 16) + TW'(pl_r) + HALF_T;
  assign r   = $signed(tot[TW-1:28]);

  always_comb begin
    if (r > SMAX_R) begin
      out_nxt = SMAX_R[SAMPLE_BITS-1:0];
    end else if (r < SMIN_R) begin
      out_nxt = SMIN_R[SAMPLE_BITS-1:0];
    end else begin
      out_nxt = r[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      x1_r  <= x_in;
      pd_r  <= pd_nxt;
      px_r  <= px_nxt;
      m_r   <= m_nxt;
      ph_r  <= ph_nxt;
      pl_r  <= pl_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_v      = v5_r;
  assign sample_out = out_r;

  `ADB_ASSERT(a_shaped_symmetric, v1_r |-> (d_r != SMIN_S), "shaped value at negative full scale")

endmodule

[sv/adb_skid.sv]
`timescale 1ns / 1ps
// output register with one skid entry, decouples the pipeline from the sink
// depends on assert_macros.svh
`include "assert_macros.svh"
module adb_skid #(
  parameter int W = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_v,
  input  logic [W-1:0] in_data,
  output logic         in_ready,
  output logic         out_v,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         out_v_r, out_v_nxt, skid_v_r, skid_v_nxt, take;
  logic [W-1:0] out_r, out_nxt, skid_r, skid_nxt;

  assign take     = out_v_r && out_ready;
  assign in_ready = !skid_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (take) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (in_v) begin
      if (!out_v_r || take) begin
        out_nxt   = in_data;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = in_data;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_v    = out_v_r;
  assign out_data = out_r;

  `ADB_ASSERT_ALWAYS(a_skid_behind_out, skid_v_r |-> out_v_r, "skid entry without output entry")
  `ADB_ASSERT(a_skid_on_stall, $rose(skid_v_r) |-> $past(out_v_r && !out_ready), "skid filled without stall")

endmodule
